@@ design/rer_pkg.sv @@
// Package for the running entropic risk block: types, constants, tables.
// Used by rer_regs, rer_div, rer_core and the top level; depends on nothing.
`default_nettype none
package rer_pkg;

    // parameter defaults
    localparam int COUNT_BITS_DEF    = 16;
    localparam int EXP_FRAC_BITS_DEF = 20;

    // widths
    localparam int SUM_W  = 48;
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;
    localparam int DIV_NW = 36;
    localparam int DIV_DW = 17;

    // arithmetic constants
    localparam logic [31:0]      LOG2E_Q30 = 32'd1549082005;
    localparam logic [31:0]      LN2_Q30   = 32'd744261118;
    localparam logic [31:0]      Q30_ONE   = 32'h4000_0000;
    localparam logic [SUM_W-1:0] SUM_MAX   = {SUM_W{1'b1}};

    // register map
    localparam logic [1:0] REG_ALPHA = 2'd0;
    localparam logic [1:0] REG_EPS   = 2'd1;
    localparam logic [1:0] REG_THR   = 2'd2;

    localparam logic [14:0] ALPHA_RST = 15'd4915;
    localparam logic [15:0] EPS_RST   = 16'd41;
    localparam logic [15:0] THR_RST   = 16'd3277;

    typedef struct packed {
        logic [14:0]        risk_aversion;
        logic [15:0]        stabilizer;
        logic signed [15:0] alert_threshold;
    } cfg_t;

    typedef struct packed {
        logic signed [15:0] risk;
        logic               alert;
        logic [15:0]        sample_count;
        logic               saturated;
    } res_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_NORM_DIV,
        ST_NORM_WAIT,
        ST_MUL_NM,
        ST_MUL_XM,
        ST_MUL_YM,
        ST_GET_T,
        ST_HORN_MUL,
        ST_HORN_RCP,
        ST_HORN_UPD,
        ST_SCALE,
        ST_RISK_CHK,
        ST_LOG_NORM,
        ST_LOG_SQ,
        ST_LOG_UPD,
        ST_RISK_MUL,
        ST_RISK_DIV,
        ST_RISK_WAIT,
        ST_FINISH
    } st_t;

    // reciprocal of the Horner divisor i, ceil(2^(31+l)/i), l = ceil(log2 i)
    function automatic logic [31:0] horner_recip(input logic [2:0] i);
        logic [31:0] m;
        case (i)
            3'd2:    m = 32'd2147483648;
            3'd3:    m = 32'd2863311531;
            3'd4:    m = 32'd2147483648;
            3'd5:    m = 32'd3435973837;
            3'd6:    m = 32'd2863311531;
            3'd7:    m = 32'd2454267027;
            default: m = 32'd2147483648;
        endcase
        return m;
    endfunction

    // right shift that goes with horner_recip
    function automatic logic [5:0] horner_shift(input logic [2:0] i);
        logic [5:0] s;
        case (i)
            3'd2:    s = 6'd32;
            3'd3:    s = 6'd33;
            3'd4:    s = 6'd33;
            3'd5:    s = 6'd34;
            3'd6:    s = 6'd34;
            3'd7:    s = 6'd34;
            default: s = 6'd31;
        endcase
        return s;
    endfunction

endpackage
`default_nettype wire

@@ design/rer_if.sv @@
// Valid/ready channel interfaces for sample beats and result beats.
// Depends on nothing.
`default_nettype none
interface rer_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] residual;
    logic               restart;

    modport source (output valid, residual, restart, input ready);
    modport sink (input valid, residual, restart, output ready);
endinterface

interface rer_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] risk;
    logic               alert;
    logic [15:0]        sample_count;
    logic               saturated;

    modport source (output valid, risk, alert, sample_count, saturated, input ready);
    modport sink (input valid, risk, alert, sample_count, saturated, output ready);
endinterface
`default_nettype wire

@@ design/rer_regs.sv @@
// APB configuration registers: risk aversion, stabilizer, alert threshold.
// Depends on rer_pkg.
`default_nettype none
module rer_regs (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [rer_pkg::ADDR_W-1:0] paddr,
    input  logic [rer_pkg::DATA_W-1:0] pwdata,
    output logic [rer_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    output rer_pkg::cfg_t              cfg
);
    import rer_pkg::*;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic [1:0] idx;
    logic       wr_en;

    assign idx    = paddr[3:2];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    // register write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                REG_ALPHA: cfg_next.risk_aversion   = pwdata[14:0];
                REG_EPS:   cfg_next.stabilizer      = pwdata[15:0];
                REG_THR:   cfg_next.alert_threshold = $signed(pwdata[15:0]);
                default:   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.risk_aversion   <= ALPHA_RST;
            cfg_reg.stabilizer      <= EPS_RST;
            cfg_reg.alert_threshold <= $signed(THR_RST);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // read mux
    always_comb
    begin
        unique case (idx)
            REG_ALPHA: prdata = 32'(cfg_reg.risk_aversion);
            REG_EPS:   prdata = 32'(cfg_reg.stabilizer);
            REG_THR:   prdata = 32'({16'd0, cfg_reg.alert_threshold});
            default:   prdata = '0;
        endcase
    end
endmodule
`default_nettype wire

@@ design/rer_mul.sv @@
// Shared 32x32 unsigned multiplier with a registered product.
// Depends on nothing.
`default_nettype none
module rer_mul (
    input  logic        clk,
    input  logic [31:0] a,
    input  logic [31:0] b,
    output logic [63:0] prod
);
    logic [63:0] prod_reg;

    // product is registered, ready in the cycle after the operands
    always_ff @(posedge clk)
    begin
        prod_reg <= 64'(a) * 64'(b);
    end

    assign prod = prod_reg;
endmodule
`default_nettype wire

@@ design/rer_div.sv @@
// Shared restoring divider, one quotient bit per cycle.
// Depends on rer_pkg for its default widths.
`default_nettype none
module rer_div #(
    parameter int NW = rer_pkg::DIV_NW,
    parameter int DW = rer_pkg::DIV_DW
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic          done,
    output logic [NW-1:0] quot
);
    localparam int CW = $clog2(NW + 1);

    logic [CW-1:0] cnt_reg;
    logic [CW-1:0] cnt_next;
    logic          done_reg;
    logic          done_next;
    logic [DW-1:0] rem_reg;
    logic [DW-1:0] rem_next;
    logic [NW-1:0] quo_reg;
    logic [NW-1:0] quo_next;
    logic [DW-1:0] den_reg;
    logic [DW:0]   trial;
    logic [DW:0]   diff;

    assign trial = {rem_reg, quo_reg[NW-1]};
    assign diff  = trial - {1'b0, den_reg};

    // one restoring step per cycle
    always_comb
    begin
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        done_next = 1'b0;
        if (start)
        begin
            cnt_next = CW'(NW);
            rem_next = '0;
            quo_next = num;
        end
        else if (cnt_reg != '0)
        begin
            cnt_next = cnt_reg - 1'b1;
            if (trial >= {1'b0, den_reg})
            begin
                rem_next = diff[DW-1:0];
                quo_next = {quo_reg[NW-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[DW-1:0];
                quo_next = {quo_reg[NW-2:0], 1'b0};
            end
            done_next = (cnt_reg == CW'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (start)
        begin
            den_reg <= den;
        end
    end

    assign done = done_reg;
    assign quot = quo_reg;
endmodule
`default_nettype wire

@@ design/rer_core.sv @@
// Sequencer and datapath: normalize, exponential, accumulate, log2, risk.
// Depends on rer_pkg, rer_mul and rer_div.
`default_nettype none
module rer_core #(
    parameter int COUNT_BITS    = rer_pkg::COUNT_BITS_DEF,
    parameter int EXP_FRAC_BITS = rer_pkg::EXP_FRAC_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  rer_pkg::cfg_t      cfg,
    input  logic               start,
    input  logic signed [15:0] residual,
    input  logic               restart,
    output logic               idle,
    output logic               res_valid,
    input  logic               res_ready,
    output rer_pkg::res_t      res
);
    import rer_pkg::*;

    localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

    st_t                    state_reg, state_next;
    logic [SUM_W-1:0]       exp_sum_reg, exp_sum_next;
    logic [COUNT_BITS-1:0]  count_reg, count_next;
    logic                   frozen_reg, frozen_next;
    logic [15:0]            mag_reg, mag_next;
    logic                   neg_reg, neg_next;
    logic signed [5:0]      k_reg, k_next;
    logic [29:0]            t_reg, t_next;
    logic [31:0]            acc_reg, acc_next;
    logic [2:0]             hi_reg, hi_next;
    logic [SUM_W-1:0]       w_reg, w_next;
    logic [5:0]             lp_reg, lp_next;
    logic [2:0]             lstep_reg, lstep_next;
    logic [30:0]            m_reg, m_next;
    logic [23:0]            frac_reg, frac_next;
    logic [4:0]             lbit_reg, lbit_next;
    logic                   lsel_reg, lsel_next;
    logic [29:0]            l2s_reg, l2s_next;
    logic [29:0]            l2c_reg, l2c_next;
    logic                   lneg_reg, lneg_next;
    logic signed [15:0]     risk_reg, risk_next;

    logic [31:0]            mul_a, mul_b;
    logic [63:0]            prod;
    logic                   div_start, div_done;
    logic [DIV_NW-1:0]      div_num, div_quot;
    logic [DIV_DW-1:0]      div_den;

    logic [14:0]            alpha_eff;
    logic [23:0]            ym;
    logic [19:0]            f_val;
    logic signed [7:0]      sh;
    logic [6:0]             nsh;
    logic [SUM_W-1:0]       e_val;
    logic [SUM_W:0]         sum_wide;
    logic [5:0]             sz;
    logic [SUM_W-1:0]       w_sh;
    logic                   top_zero;
    logic [31:0]            mm;
    logic [23:0]            frac_new;
    logic signed [31:0]     l_val;
    logic [30:0]            l_mag;
    logic [31:0]            cnt_ext;

    rer_mul u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    rer_div #(
        .NW (DIV_NW),
        .DW (DIV_DW)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (div_quot)
    );

    assign alpha_eff = (cfg.risk_aversion == '0) ? 15'd1 : cfg.risk_aversion;
    assign ym        = prod[53:30];
    assign cnt_ext   = 32'(count_reg);

    // scale of the exponential: 2^k with the fraction point moved
    assign sh  = 8'(k_reg) + 8'(EXP_FRAC_BITS) - 8'sd30;
    assign nsh = 7'(-sh);

    always_comb
    begin
        if (sh >= 0)
        begin
            if (sh > 8'sd16)
            begin
                e_val = SUM_MAX;
            end
            else
            begin
                e_val = {16'd0, acc_reg} << sh[4:0];
            end
        end
        else if (nsh >= 7'd63)
        begin
            e_val = '0;
        end
        else
        begin
            e_val = SUM_W'(acc_reg >> nsh[5:0]);
        end
    end

    assign sum_wide = {1'b0, exp_sum_reg} + {1'b0, e_val};

    // leading-zero search step size
    always_comb
    begin
        case (lstep_reg)
            3'd0:    sz = 6'd32;
            3'd1:    sz = 6'd16;
            3'd2:    sz = 6'd8;
            3'd3:    sz = 6'd4;
            3'd4:    sz = 6'd2;
            default: sz = 6'd1;
        endcase
    end

    assign top_zero = ((w_reg >> (6'(SUM_W) - sz)) == '0);
    assign w_sh     = top_zero ? (w_reg << sz) : w_reg;
    assign mm       = prod[61:30];
    assign frac_new = {frac_reg[22:0], mm[31]};

    // log ratio minus the fraction scaling of the sum
    assign l_val = $signed({2'b00, l2s_reg}) - $signed({2'b00, l2c_reg})
                 - $signed(32'(EXP_FRAC_BITS) << 24);
    assign l_mag = (l_val < 0) ? 31'(-l_val) : 31'(l_val);

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        exp_sum_next = exp_sum_reg;
        count_next   = count_reg;
        frozen_next  = frozen_reg;
        mag_next     = mag_reg;
        neg_next     = neg_reg;
        k_next       = k_reg;
        t_next       = t_reg;
        acc_next     = acc_reg;
        hi_next      = hi_reg;
        w_next       = w_reg;
        lp_next      = lp_reg;
        lstep_next   = lstep_reg;
        m_next       = m_reg;
        frac_next    = frac_reg;
        lbit_next    = lbit_reg;
        lsel_next    = lsel_reg;
        l2s_next     = l2s_reg;
        l2c_next     = l2c_reg;
        lneg_next    = lneg_reg;
        risk_next    = risk_reg;
        mul_a        = '0;
        mul_b        = '0;
        div_start    = 1'b0;
        div_num      = '0;
        div_den      = '0;
        f_val        = '0;
        idle         = 1'b0;
        res_valid    = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                idle = 1'b1;
                if (start)
                begin
                    neg_next = residual[15];
                    mag_next = residual[15] ? 16'(-residual) : residual;
                    if (restart)
                    begin
                        exp_sum_next = '0;
                        count_next   = '0;
                        frozen_next  = 1'b0;
                        state_next   = ST_NORM_DIV;
                    end
                    else if (frozen_reg)
                    begin
                        state_next = ST_RISK_CHK;
                    end
                    else
                    begin
                        state_next = ST_NORM_DIV;
                    end
                end
            end
            ST_NORM_DIV:
            begin
                div_start  = 1'b1;
                div_num    = {mag_reg, 20'd0};
                div_den    = 17'd4096 + 17'(cfg.stabilizer) + 17'(mag_reg);
                state_next = ST_NORM_WAIT;
            end
            ST_NORM_WAIT:
            begin
                if (div_done)
                begin
                    state_next = ST_MUL_NM;
                end
            end
            ST_MUL_NM:
            begin
                mul_a      = 32'(alpha_eff);
                mul_b      = 32'(div_quot[20:0]);
                state_next = ST_MUL_XM;
            end
            ST_MUL_XM:
            begin
                mul_a      = 32'(prod[34:12]);
                mul_b      = LOG2E_Q30;
                state_next = ST_MUL_YM;
            end
            ST_MUL_YM:
            begin
                // split y into integer k and fraction f in [0,1)
                if (!neg_reg)
                begin
                    k_next = $signed({2'b00, ym[23:20]});
                    f_val  = ym[19:0];
                end
                else if (ym[19:0] == '0)
                begin
                    k_next = -$signed({2'b00, ym[23:20]});
                    f_val  = '0;
                end
                else
                begin
                    k_next = -$signed({2'b00, ym[23:20]}) - 6'sd1;
                    f_val  = 20'(21'h10_0000 - {1'b0, ym[19:0]});
                end
                mul_a      = 32'({f_val, 10'd0});
                mul_b      = LN2_Q30;
                state_next = ST_GET_T;
            end
            ST_GET_T:
            begin
                t_next     = prod[59:30];
                acc_next   = Q30_ONE;
                hi_next    = 3'd7;
                state_next = ST_HORN_MUL;
            end
            ST_HORN_MUL:
            begin
                mul_a      = 32'(t_reg);
                mul_b      = acc_reg;
                state_next = ST_HORN_RCP;
            end
            ST_HORN_RCP:
            begin
                mul_a      = 32'(prod[60:30]);
                mul_b      = horner_recip(hi_reg);
                state_next = ST_HORN_UPD;
            end
            ST_HORN_UPD:
            begin
                acc_next = Q30_ONE + 32'(prod >> horner_shift(hi_reg));
                if (hi_reg == 3'd1)
                begin
                    state_next = ST_SCALE;
                end
                else
                begin
                    hi_next    = hi_reg - 3'd1;
                    state_next = ST_HORN_MUL;
                end
            end
            ST_SCALE:
            begin
                // saturating accumulate and count
                if (sum_wide[SUM_W])
                begin
                    exp_sum_next = SUM_MAX;
                    frozen_next  = 1'b1;
                end
                else
                begin
                    exp_sum_next = sum_wide[SUM_W-1:0];
                end
                if (count_reg != CNT_MAX)
                begin
                    count_next = count_reg + 1'b1;
                end
                if (count_reg >= CNT_MAX - 1'b1)
                begin
                    frozen_next = 1'b1;
                end
                state_next = ST_RISK_CHK;
            end
            ST_RISK_CHK:
            begin
                if (count_reg == '0)
                begin
                    risk_next  = 16'sd0;
                    state_next = ST_FINISH;
                end
                else if (exp_sum_reg == '0)
                begin
                    risk_next  = -16'sd32768;
                    state_next = ST_FINISH;
                end
                else
                begin
                    w_next     = exp_sum_reg;
                    lp_next    = 6'd47;
                    lstep_next = 3'd0;
                    lsel_next  = 1'b0;
                    state_next = ST_LOG_NORM;
                end
            end
            ST_LOG_NORM:
            begin
                w_next = w_sh;
                if (top_zero)
                begin
                    lp_next = lp_reg - sz;
                end
                if (lstep_reg == 3'd5)
                begin
                    m_next     = w_sh[SUM_W-1:SUM_W-31];
                    frac_next  = '0;
                    lbit_next  = 5'd24;
                    state_next = ST_LOG_SQ;
                end
                else
                begin
                    lstep_next = lstep_reg + 3'd1;
                end
            end
            ST_LOG_SQ:
            begin
                mul_a      = 32'(m_reg);
                mul_b      = 32'(m_reg);
                state_next = ST_LOG_UPD;
            end
            ST_LOG_UPD:
            begin
                m_next    = mm[31] ? mm[31:1] : mm[30:0];
                frac_next = frac_new;
                lbit_next = lbit_reg - 5'd1;
                if (lbit_reg == 5'd1)
                begin
                    if (!lsel_reg)
                    begin
                        l2s_next   = {lp_reg, frac_new};
                        lsel_next  = 1'b1;
                        w_next     = SUM_W'(count_reg);
                        lp_next    = 6'd47;
                        lstep_next = 3'd0;
                        state_next = ST_LOG_NORM;
                    end
                    else
                    begin
                        l2c_next   = {lp_reg, frac_new};
                        state_next = ST_RISK_MUL;
                    end
                end
                else
                begin
                    state_next = ST_LOG_SQ;
                end
            end
            ST_RISK_MUL:
            begin
                lneg_next  = (l_val < 0);
                mul_a      = 32'(l_mag);
                mul_b      = LN2_Q30;
                state_next = ST_RISK_DIV;
            end
            ST_RISK_DIV:
            begin
                div_start  = 1'b1;
                div_num    = DIV_NW'(prod >> 27);
                div_den    = DIV_DW'(alpha_eff);
                state_next = ST_RISK_WAIT;
            end
            ST_RISK_WAIT:
            begin
                if (div_done)
                begin
                    if (lneg_reg)
                    begin
                        risk_next = (div_quot >= DIV_NW'(32768)) ? -16'sd32768
                                  : -$signed(div_quot[15:0]);
                    end
                    else
                    begin
                        risk_next = (div_quot >= DIV_NW'(32767)) ? 16'sd32767
                                  : $signed(div_quot[15:0]);
                    end
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            exp_sum_reg <= '0;
            count_reg   <= '0;
            frozen_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            exp_sum_reg <= exp_sum_next;
            count_reg   <= count_next;
            frozen_reg  <= frozen_next;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        mag_reg   <= mag_next;
        neg_reg   <= neg_next;
        k_reg     <= k_next;
        t_reg     <= t_next;
        acc_reg   <= acc_next;
        hi_reg    <= hi_next;
        w_reg     <= w_next;
        lp_reg    <= lp_next;
        lstep_reg <= lstep_next;
        m_reg     <= m_next;
        frac_reg  <= frac_next;
        lbit_reg  <= lbit_next;
        lsel_reg  <= lsel_next;
        l2s_reg   <= l2s_next;
        l2c_reg   <= l2c_next;
        lneg_reg  <= lneg_next;
        risk_reg  <= risk_next;
    end

    // result beat
    assign res.risk         = risk_reg;
    assign res.alert        = (risk_reg > cfg.alert_threshold);
    assign res.sample_count = cnt_ext[15:0];
    assign res.saturated    = frozen_reg;
endmodule
`default_nettype wire

@@ design/running_entropic_risk_unit.sv @@
// Running entropic risk unit: sample channel in, result channel out, APB config.
// Top level; depends on rer_pkg, rer_if, rer_regs, rer_core.
//
// Usage:
//  - sample_in carries one residual (Q3.12) and a restart bit per beat;
//    restart clears the sum, count and freeze flag before that sample.
//  - result_out carries risk (Q0.15), alert, sample_count and saturated,
//    exactly one result beat per sample beat, in order.
//  - A sample runs from its accepting edge to its result entering the
//    output register through two divider waits, the Horner steps, two
//    log2 runs of 6 search steps and 24 squarings each, and sequencing
//    states; no new sample is taken until the last one is through.
//    A frozen sample skips the normalizing division and the exponential.
//  - sample_in.ready is high only while the sequencer is idle.
//  - A result waits in the output register; the next sample is taken
//    meanwhile, and its result waits in the core while the receiver stalls.
//  - Once frozen, samples only re-report the held state until a restart.
//  - Reset clears sum, count and freeze flag and loads register defaults.
//  - User writes configuration through APB while block is idle; not enforced.
`default_nettype none
module running_entropic_risk_unit #(
    parameter int COUNT_BITS    = rer_pkg::COUNT_BITS_DEF,
    parameter int EXP_FRAC_BITS = rer_pkg::EXP_FRAC_BITS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    rer_in_if.sink                     sample_in,
    rer_out_if.source                  result_out,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [rer_pkg::ADDR_W-1:0] paddr,
    input  logic [rer_pkg::DATA_W-1:0] pwdata,
    output logic [rer_pkg::DATA_W-1:0] prdata,
    output logic                       pready
);
    import rer_pkg::*;

    cfg_t cfg;
    res_t res;
    res_t res_reg;
    logic idle;
    logic res_valid;
    logic res_ready;
    logic out_valid_reg;
    logic out_valid_next;

    rer_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    rer_core #(
        .COUNT_BITS    (COUNT_BITS),
        .EXP_FRAC_BITS (EXP_FRAC_BITS)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .start     (sample_in.valid && idle),
        .residual  (sample_in.residual),
        .restart   (sample_in.restart),
        .idle      (idle),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    assign sample_in.ready = idle;

    // output register between the core and the receiver
    assign res_ready = !out_valid_reg || result_out.ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_valid && res_ready)
        begin
            out_valid_next = 1'b1;
        end
        else if (result_out.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            res_reg <= res;
        end
    end

    assign result_out.valid        = out_valid_reg;
    assign result_out.risk         = res_reg.risk;
    assign result_out.alert        = res_reg.alert;
    assign result_out.sample_count = res_reg.sample_count;
    assign result_out.saturated    = res_reg.saturated;
endmodule
`default_nettype wire
